>>> rtl/pf_pkg.sv
// Shared constants and types of the prime factorizer.
package pf_pkg;

  localparam int unsigned VALUE_WIDTH  = 32;
  localparam int unsigned IN_WIDTH     = 32;
  localparam int unsigned PRIME_WIDTH  = 32;
  localparam int unsigned EXP_WIDTH    = 5;
  localparam int unsigned OUT_WIDTH    = 40;
  localparam int unsigned MAX_RESULTS  = 9;
  localparam int unsigned CNT_WIDTH    = 4;
  localparam logic [EXP_WIDTH-1:0] EXP_MAX = 5'd31;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_PUSH   = 7'b0010000,
    S_TAIL   = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_e;

endpackage

>>> rtl/prime_factorizer.sv
// Trial-division prime factorizer with one shared bit-serial divider.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: value
//  m_axis   | out | m_axis_tvalid/tready    | tdata: prime, exponent; tlast; tuser
//
// Each trial division shifts all VALUE_WIDTH quotient bits through the restoring
// divider and then does its bookkeeping in S_DECIDE and S_CHECK; an item with
// largest trial divisor P runs through the trial divisors 2 to P in turn.
// The input is ready only while no item is in progress.
// One result is held back until the next is known, so that tlast can be set.
// A stalled output only halts the sequencer when it must hand over a result.
// Reset is asynchronous and active low; it clears the sequencer and valids.
module prime_factorizer #(
  parameter int unsigned VALUE_WIDTH = pf_pkg::VALUE_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [31:0] value
  input  logic [pf_pkg::IN_WIDTH-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [31:0] prime, [36:32] exponent, [39:37] zero
  output logic [pf_pkg::OUT_WIDTH-1:0] m_axis_tdata_o,
  output logic                         m_axis_tlast_o,
  // [0] empty_res
  output logic                         m_axis_tuser_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned IW = (W < pf_pkg::IN_WIDTH) ? W : pf_pkg::IN_WIDTH;
  localparam int unsigned PW = W / 2 + 2;
  localparam int unsigned SW = W + 2;
  localparam int unsigned XW = W + pf_pkg::PRIME_WIDTH;
  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned PAD = pf_pkg::OUT_WIDTH - pf_pkg::PRIME_WIDTH - pf_pkg::EXP_WIDTH;

  pf_pkg::state_e state_q, state_d;

  logic [W-1:0]                   n_q, n_d;
  logic [PW-1:0]                  p_q, p_d;
  logic [SW-1:0]                  sq_q, sq_d;
  logic [pf_pkg::EXP_WIDTH-1:0]   e_q, e_d;
  logic [pf_pkg::CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic [PW-1:0]                  rem_q, rem_d;
  logic [W-1:0]                   quo_q, quo_d;
  logic [CW-1:0]                  bit_q, bit_d;

  logic                           pend_valid_q, pend_valid_d;
  logic [pf_pkg::PRIME_WIDTH-1:0] pend_prime_q, pend_prime_d;
  logic [pf_pkg::EXP_WIDTH-1:0]   pend_exp_q, pend_exp_d;
  logic                           pend_empty_q, pend_empty_d;

  logic                           out_valid_q, out_valid_d;
  logic [pf_pkg::PRIME_WIDTH-1:0] out_prime_q, out_prime_d;
  logic [pf_pkg::EXP_WIDTH-1:0]   out_exp_q, out_exp_d;
  logic                           out_last_q, out_last_d;
  logic                           out_empty_q, out_empty_d;

  logic [W-1:0]  n_init;
  logic [PW:0]   trial;
  logic [PW:0]   diff;
  logic          ge;
  logic          out_free;
  logic          push_ok;
  logic          room;
  logic [XW-1:0] p_ext;
  logic [XW-1:0] n_ext;

  assign n_init   = W'(s_axis_tdata_i[IW-1:0]);
  assign trial    = {rem_q, quo_q[W-1]};
  assign diff     = trial - {1'b0, p_q};
  assign ge       = ~diff[PW];
  assign out_free = ~out_valid_q | m_axis_tready_i;
  assign push_ok  = ~pend_valid_q | out_free;
  assign room     = cnt_q < pf_pkg::CNT_WIDTH'(pf_pkg::MAX_RESULTS);
  assign p_ext    = XW'(p_q);
  assign n_ext    = XW'(n_q);

  always_comb begin
    state_d      = state_q;
    n_d          = n_q;
    p_d          = p_q;
    sq_d         = sq_q;
    e_d          = e_q;
    cnt_d        = cnt_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    bit_d        = bit_q;
    pend_valid_d = pend_valid_q;
    pend_prime_d = pend_prime_q;
    pend_exp_d   = pend_exp_q;
    pend_empty_d = pend_empty_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_prime_d  = out_prime_q;
    out_exp_d    = out_exp_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;

    case (state_q)
      pf_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          n_d = n_init;
          if (n_init < W'(2)) begin
            pend_valid_d = 1'b1;
            pend_prime_d = '0;
            pend_exp_d   = '0;
            pend_empty_d = 1'b1;
            state_d      = pf_pkg::S_FLUSH;
          end else begin
            p_d     = PW'(2);
            sq_d    = SW'(4);
            e_d     = '0;
            cnt_d   = '0;
            state_d = pf_pkg::S_CHECK;
          end
        end
      end
      pf_pkg::S_CHECK: begin
        if (SW'(n_q) >= sq_q && room) begin
          rem_d   = '0;
          quo_d   = n_q;
          bit_d   = CW'(W);
          state_d = pf_pkg::S_DIV;
        end else begin
          state_d = pf_pkg::S_TAIL;
        end
      end
      pf_pkg::S_DIV: begin
        rem_d = ge ? diff[PW-1:0] : trial[PW-1:0];
        quo_d = {quo_q[W-2:0], ge};
        bit_d = bit_q - CW'(1);
        if (bit_q == CW'(1)) begin
          state_d = pf_pkg::S_DECIDE;
        end
      end
      pf_pkg::S_DECIDE: begin
        if (rem_q == '0) begin
          // Divisor divides: keep the quotient and divide again.
          n_d     = quo_q;
          e_d     = (e_q == pf_pkg::EXP_MAX) ? e_q : e_q + 1'b1;
          rem_d   = '0;
          quo_d   = quo_q;
          bit_d   = CW'(W);
          state_d = pf_pkg::S_DIV;
        end else if (e_q != '0) begin
          state_d = pf_pkg::S_PUSH;
        end else begin
          p_d     = p_q + 1'b1;
          sq_d    = sq_q + SW'({p_q, 1'b1});
          state_d = pf_pkg::S_CHECK;
        end
      end
      pf_pkg::S_PUSH: begin
        if (push_ok) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_prime_d = pend_prime_q;
            out_exp_d   = pend_exp_q;
            out_last_d  = 1'b0;
            out_empty_d = pend_empty_q;
          end
          pend_valid_d = 1'b1;
          pend_prime_d = p_ext[pf_pkg::PRIME_WIDTH-1:0];
          pend_exp_d   = e_q;
          pend_empty_d = 1'b0;
          cnt_d        = cnt_q + 1'b1;
          e_d          = '0;
          p_d          = p_q + 1'b1;
          sq_d         = sq_q + SW'({p_q, 1'b1});
          state_d      = pf_pkg::S_CHECK;
        end
      end
      pf_pkg::S_TAIL: begin
        if (n_q > W'(1) && room) begin
          // The cofactor left over is itself prime.
          if (push_ok) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_prime_d = pend_prime_q;
              out_exp_d   = pend_exp_q;
              out_last_d  = 1'b0;
              out_empty_d = pend_empty_q;
            end
            pend_valid_d = 1'b1;
            pend_prime_d = n_ext[pf_pkg::PRIME_WIDTH-1:0];
            pend_exp_d   = pf_pkg::EXP_WIDTH'(1);
            pend_empty_d = 1'b0;
            cnt_d        = cnt_q + 1'b1;
            n_d          = W'(1);
            state_d      = pf_pkg::S_FLUSH;
          end
        end else begin
          state_d = pf_pkg::S_FLUSH;
        end
      end
      pf_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_prime_d  = pend_prime_q;
          out_exp_d    = pend_exp_q;
          out_last_d   = 1'b1;
          out_empty_d  = pend_empty_q;
          pend_valid_d = 1'b0;
          state_d      = pf_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pf_pkg::S_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      bit_q        <= '0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      bit_q        <= bit_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q          <= n_d;
    p_q          <= p_d;
    sq_q         <= sq_d;
    e_q          <= e_d;
    rem_q        <= rem_d;
    quo_q        <= quo_d;
    pend_prime_q <= pend_prime_d;
    pend_exp_q   <= pend_exp_d;
    pend_empty_q <= pend_empty_d;
    out_prime_q  <= out_prime_d;
    out_exp_q    <= out_exp_d;
    out_last_q   <= out_last_d;
    out_empty_q  <= out_empty_d;
  end

  assign s_axis_tready_o = (state_q == pf_pkg::S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {PAD'(0), out_exp_q, out_prime_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_empty_q;

endmodule

>>> rtl/pf_checker.sv
// Port-level checks of the prime factorizer and their binding.
module pf_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid_i,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [pf_pkg::OUT_WIDTH-1:0] m_axis_tdata_o,
  input logic                         m_axis_tlast_o,
  input logic                         m_axis_tuser_o
);

  // An empty result is the only and last result of its item and carries zeros.
  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o == '0)
    else $error("empty result malformed");

  // A real factor is at least two with a nonzero exponent.
  a_factor_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      m_axis_tdata_o[pf_pkg::PRIME_WIDTH-1:0] >= 32'd2 &&
      m_axis_tdata_o[pf_pkg::PRIME_WIDTH+pf_pkg::EXP_WIDTH-1:pf_pkg::PRIME_WIDTH] != '0)
    else $error("factor result malformed");

  // Once an item is taken the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready did not drop after an accepted item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) &&
      $stable(m_axis_tuser_o))
    else $error("stalled result changed");

endmodule

bind prime_factorizer pf_checker u_pf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
